// ----- src/mtes_pkg.sv -----
// Shared types and constants of the muon plus e/gamma threshold scanner.
`timescale 1ns / 1ps

package mtes_pkg;

   typedef enum logic [1:0] {
      OP_MUON = 2'd0,
      OP_EG   = 2'd1,
      OP_END  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_MUON_ETA_LIMIT   = 3'd0,
      CSR_MUON_QUALITY_MIN = 3'd1,
      CSR_EG_ETA_LIMIT     = 3'd2,
      CSR_DR_SQUARED_LIMIT = 3'd3,
      CSR_THRESHOLD_STEP   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQUARE,
      ST_JUDGE,
      ST_SWEEP,
      ST_READ
   } state_type;

   localparam logic [6:0]  MUON_ETA_LIMIT_RST   = 7'd23;
   localparam logic [3:0]  MUON_QUALITY_MIN_RST = 4'd12;
   localparam logic [6:0]  EG_ETA_LIMIT_RST     = 7'd25;
   localparam logic [15:0] DR_SQUARED_LIMIT_RST = 16'd528;
   localparam logic [7:0]  THRESHOLD_STEP_RST   = 8'd2;

   // Phi wraps at 144 steps per turn; the difference is folded into -72..71.
   localparam logic signed [9:0] PHI_TURN     = 10'sd144;
   localparam logic signed [9:0] PHI_HALF     = 10'sd72;
   localparam logic signed [9:0] PHI_NEG_HALF = -10'sd72;

   typedef struct packed {
      logic take;
      logic end_evt;
      logic judge;
      logic clear;
   } evt_cmd_type;

   typedef struct packed {
      logic [8:0] muon_energy;
      logic [8:0] eg_lead_energy;
      logic       pair_pass;
   } evt_status_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] count;
   } read_result_type;

endpackage

// ----- src/mtes_grid_ram.sv -----
// Synchronous count memory with one write port and one registered read port.
`timescale 1ns / 1ps

module mtes_grid_ram #(
   parameter int DEPTH  = 100,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mtes_event.sv -----
// Per-event object selection and the squared dR test of the e/gamma pair.
`timescale 1ns / 1ps

module mtes_event
   import mtes_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  evt_cmd_type    cmd,
   input  op_type         req_opcode,
   input  logic [8:0]     req_energy,
   input  logic [7:0]     req_eta_pos,
   input  logic [7:0]     req_phi_pos,
   input  logic [3:0]     req_quality,
   input  logic [6:0]     muon_eta_limit,
   input  logic [3:0]     muon_quality_min,
   input  logic [6:0]     eg_eta_limit,
   input  logic [15:0]    dr_squared_limit,
   output evt_status_type status
);

   logic       muon_found_ff, muon_found_in;
   logic [8:0] muon_energy_ff, muon_energy_in;
   logic [1:0] eg_taken_ff, eg_taken_in;
   logic [8:0] eg_lead_ff, eg_lead_in;
   logic [7:0] eg_eta_ff [2];
   logic [7:0] eg_phi_ff [2];
   logic [15:0] deta_sq_ff, deta_sq_in;
   logic [12:0] dphi_sq_ff, dphi_sq_in;
   logic        pass_ff, pass_in;

   logic [7:0]         abs_eta;
   logic               muon_ok;
   logic               eg_ok;
   logic               eg_store;
   logic signed [8:0]  deta;
   logic signed [17:0] deta_sq_full;
   logic signed [9:0]  dphi_raw;
   logic signed [9:0]  dphi_mid;
   logic signed [9:0]  dphi;
   logic signed [19:0] dphi_sq_full;
   logic [16:0]        dr_sq;

   always_comb begin
      abs_eta  = req_eta_pos[7] ? 8'(-req_eta_pos) : req_eta_pos;
      muon_ok  = !muon_found_ff && (abs_eta <= {1'b0, muon_eta_limit})
                 && (req_quality >= muon_quality_min);
      eg_ok    = (eg_taken_ff != 2'd2) && (abs_eta <= {1'b0, eg_eta_limit});
      eg_store = cmd.take && (req_opcode == OP_EG) && eg_ok;

      muon_found_in  = muon_found_ff;
      muon_energy_in = muon_energy_ff;
      eg_taken_in    = eg_taken_ff;
      eg_lead_in     = eg_lead_ff;
      if (cmd.clear) begin
         muon_found_in  = 1'b0;
         muon_energy_in = '0;
         eg_taken_in    = '0;
         eg_lead_in     = '0;
      end else if (cmd.take) begin
         if (req_opcode == OP_MUON && muon_ok) begin
            muon_found_in  = 1'b1;
            muon_energy_in = req_energy;
         end
         if (eg_store) begin
            eg_taken_in = eg_taken_ff + 2'd1;
            if (eg_taken_ff == 2'd0) begin
               eg_lead_in = req_energy;
            end
         end
      end
   end

   // Square stage: the azimuth difference is folded by at most two turns each way.
   always_comb begin
      deta         = $signed({eg_eta_ff[0][7], eg_eta_ff[0]})
                     - $signed({eg_eta_ff[1][7], eg_eta_ff[1]});
      deta_sq_full = deta * deta;
      dphi_raw     = $signed({2'b00, eg_phi_ff[0]}) - $signed({2'b00, eg_phi_ff[1]});
      if (dphi_raw >= PHI_HALF) begin
         dphi_mid = dphi_raw - PHI_TURN;
      end else if (dphi_raw < PHI_NEG_HALF) begin
         dphi_mid = dphi_raw + PHI_TURN;
      end else begin
         dphi_mid = dphi_raw;
      end
      if (dphi_mid >= PHI_HALF) begin
         dphi = dphi_mid - PHI_TURN;
      end else if (dphi_mid < PHI_NEG_HALF) begin
         dphi = dphi_mid + PHI_TURN;
      end else begin
         dphi = dphi_mid;
      end
      dphi_sq_full = dphi * dphi;
      deta_sq_in   = cmd.end_evt ? 16'(deta_sq_full) : deta_sq_ff;
      dphi_sq_in   = cmd.end_evt ? 13'(dphi_sq_full) : dphi_sq_ff;

      dr_sq   = 17'(deta_sq_ff) + 17'(dphi_sq_ff);
      pass_in = cmd.judge ? ((eg_taken_ff == 2'd2) && (dr_sq <= {1'b0, dr_squared_limit}))
                          : pass_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         muon_found_ff  <= 1'b0;
         muon_energy_ff <= '0;
         eg_taken_ff    <= '0;
         eg_lead_ff     <= '0;
         pass_ff        <= 1'b0;
      end else begin
         muon_found_ff  <= muon_found_in;
         muon_energy_ff <= muon_energy_in;
         eg_taken_ff    <= eg_taken_in;
         eg_lead_ff     <= eg_lead_in;
         pass_ff        <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eg_store) begin
         eg_eta_ff[eg_taken_ff[0]] <= req_eta_pos;
         eg_phi_ff[eg_taken_ff[0]] <= req_phi_pos;
      end
      deta_sq_ff <= deta_sq_in;
      dphi_sq_ff <= dphi_sq_in;
   end

   assign status.muon_energy    = muon_energy_ff;
   assign status.eg_lead_energy = eg_lead_ff;
   assign status.pair_pass      = pass_ff;

endmodule

// ----- src/mtes_ctrl.sv -----
// Sequencer for the grid memory: clearing pass, bin sweep with write-back, bin reads.
`timescale 1ns / 1ps

module mtes_ctrl
   import mtes_pkg::*;
#(
   parameter int MUON_STEPS = 10,
   parameter int EG_STEPS   = 10,
   parameter int COUNT_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  op_type          req_opcode,
   input  logic [3:0]      req_bin_muon,
   input  logic [3:0]      req_bin_eg,
   input  logic [7:0]      threshold_step,
   input  logic            rsp_busy,
   input  evt_status_type  status,
   output logic            req_stall,
   output evt_cmd_type     cmd,
   output read_result_type rd_result
);

   localparam int GRID     = MUON_STEPS * EG_STEPS;
   localparam int ADDR_W   = (GRID > 1) ? $clog2(GRID) : 1;
   localparam int M_W      = (MUON_STEPS > 1) ? $clog2(MUON_STEPS) : 1;
   localparam int E_W      = (EG_STEPS > 1) ? $clog2(EG_STEPS) : 1;
   localparam int M_THR_W  = 9 + $clog2(MUON_STEPS + 1);
   localparam int E_THR_W  = 9 + $clog2(EG_STEPS + 1);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [M_W-1:0]     m_cnt_ff, m_cnt_in;
   logic [E_W-1:0]     e_cnt_ff, e_cnt_in;
   logic [M_THR_W-1:0] m_thr_ff, m_thr_in;
   logic [E_THR_W-1:0] e_thr_ff, e_thr_in;
   logic               wb_valid_ff, wb_valid_in;
   logic               wb_pass_ff, wb_pass_in;
   logic [ADDR_W-1:0]  wb_addr_ff, wb_addr_in;
   logic               rd_zero_ff, rd_zero_in;

   logic                  accept;
   logic                  addr_last;
   logic                  e_last;
   logic                  bin_in_range;
   logic [ADDR_W-1:0]     bin_addr;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_rd_data;

   mtes_grid_ram #(
      .DEPTH  (GRID),
      .WIDTH  (COUNT_BITS),
      .ADDR_W (ADDR_W)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A read waits while the last sweep write is in flight or a response is still held.
   assign req_stall = (state_ff != ST_IDLE) || wb_valid_ff
                      || (req_opcode == OP_READ && rsp_busy);
   assign accept    = req_valid && !req_stall;
   assign addr_last = (addr_ff == ADDR_W'(GRID - 1));
   assign e_last    = (e_cnt_ff == E_W'(EG_STEPS - 1));

   always_comb begin
      bin_in_range = ({2'b00, req_bin_muon} < 6'(MUON_STEPS))
                     && ({2'b00, req_bin_eg} < 6'(EG_STEPS));
      bin_addr     = ADDR_W'(req_bin_muon * EG_STEPS + req_bin_eg);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_opcode == OP_END) begin
               state_in = ST_SQUARE;
            end else if (accept && req_opcode == OP_READ) begin
               state_in = ST_READ;
            end
         end
         ST_SQUARE: state_in = ST_JUDGE;
         ST_JUDGE:  state_in = status.pair_pass ? ST_SWEEP : ST_IDLE;
         ST_SWEEP: begin
            if (addr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = addr_ff;
      ram_wr_en   = wb_valid_ff && wb_pass_ff;
      ram_wr_addr = wb_addr_ff;
      ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 1'b1;
      rd_result.valid = 1'b0;
      rd_result.count = rd_zero_ff ? '0 : 32'(ram_rd_data);
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            cmd.take    = accept && (req_opcode == OP_MUON || req_opcode == OP_EG);
            cmd.end_evt = accept && (req_opcode == OP_END);
            ram_rd_en   = accept && (req_opcode == OP_READ) && bin_in_range;
            ram_rd_addr = bin_addr;
         end
         ST_SQUARE: cmd.judge = 1'b1;
         ST_JUDGE:  cmd.clear = !status.pair_pass;
         ST_SWEEP: begin
            ram_rd_en = 1'b1;
            cmd.clear = addr_last;
         end
         ST_READ:   rd_result.valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      addr_in     = '0;
      m_cnt_in    = '0;
      e_cnt_in    = '0;
      m_thr_in    = '0;
      e_thr_in    = '0;
      wb_valid_in = 1'b0;
      wb_pass_in  = 1'b0;
      wb_addr_in  = addr_ff;
      rd_zero_in  = rd_zero_ff;
      if (state_ff == ST_CLEAR) begin
         addr_in = addr_last ? '0 : addr_ff + 1'b1;
      end
      if (state_ff == ST_SWEEP) begin
         wb_valid_in = 1'b1;
         wb_pass_in  = (M_THR_W'(status.muon_energy) >= m_thr_ff)
                       && (E_THR_W'(status.eg_lead_energy) >= e_thr_ff);
         if (!addr_last) begin
            addr_in = addr_ff + 1'b1;
            if (e_last) begin
               m_cnt_in = m_cnt_ff + 1'b1;
               m_thr_in = m_thr_ff + M_THR_W'(threshold_step);
            end else begin
               m_cnt_in = m_cnt_ff;
               m_thr_in = m_thr_ff;
               e_cnt_in = e_cnt_ff + 1'b1;
               e_thr_in = e_thr_ff + E_THR_W'(threshold_step);
            end
         end
      end
      if (state_ff == ST_IDLE && accept && req_opcode == OP_READ) begin
         rd_zero_in = !bin_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         addr_ff     <= '0;
         m_cnt_ff    <= '0;
         e_cnt_ff    <= '0;
         m_thr_ff    <= '0;
         e_thr_ff    <= '0;
         wb_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         m_cnt_ff    <= m_cnt_in;
         e_cnt_ff    <= e_cnt_in;
         m_thr_ff    <= m_thr_in;
         e_thr_ff    <= e_thr_in;
         wb_valid_ff <= wb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_pass_ff <= wb_pass_in;
      wb_addr_ff <= wb_addr_in;
      rd_zero_ff <= rd_zero_in;
   end

endmodule

// ----- src/muon_two_eg_threshold_scan.sv -----
// Top level of the muon plus two e/gamma threshold-grid rate scanner.
// A muon or e/gamma request is taken when it is accepted in the idle state;
// a read-bin request is answered through the registered memory read, the read
// state and the output register, and blocks the next request in the read state.
// End of event passes the square and judge states and, when the pair passes,
// sweeps every grid bin with a final write-back. Reset is synchronous; afterwards
// the grid memory is zeroed one bin per cycle while requests are stalled.
`timescale 1ns / 1ps

module muon_two_eg_threshold_scan
   import mtes_pkg::*;
#(
   parameter int MUON_STEPS = 10,
   parameter int EG_STEPS   = 10,
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [8:0]  req_energy,
   input  logic [7:0]  req_eta_pos,
   input  logic [7:0]  req_phi_pos,
   input  logic [3:0]  req_quality,
   input  logic [3:0]  req_bin_muon,
   input  logic [3:0]  req_bin_eg,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_bin_count
);

   logic [6:0]  muon_eta_limit_ff;
   logic [3:0]  muon_quality_min_ff;
   logic [6:0]  eg_eta_limit_ff;
   logic [15:0] dr_squared_limit_ff;
   logic [7:0]  threshold_step_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_bin_count_ff;

   evt_cmd_type     cmd;
   evt_status_type  status;
   read_result_type rd_result;
   op_type          opcode;

   assign opcode = op_type'(req_opcode);

   always_ff @(posedge clock) begin
      if (reset) begin
         muon_eta_limit_ff   <= MUON_ETA_LIMIT_RST;
         muon_quality_min_ff <= MUON_QUALITY_MIN_RST;
         eg_eta_limit_ff     <= EG_ETA_LIMIT_RST;
         dr_squared_limit_ff <= DR_SQUARED_LIMIT_RST;
         threshold_step_ff   <= THRESHOLD_STEP_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MUON_ETA_LIMIT:   muon_eta_limit_ff   <= csr_data[6:0];
            CSR_MUON_QUALITY_MIN: muon_quality_min_ff <= csr_data[3:0];
            CSR_EG_ETA_LIMIT:     eg_eta_limit_ff     <= csr_data[6:0];
            CSR_DR_SQUARED_LIMIT: dr_squared_limit_ff <= csr_data;
            CSR_THRESHOLD_STEP:   threshold_step_ff   <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   mtes_event u_event (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (opcode),
      .req_energy       (req_energy),
      .req_eta_pos      (req_eta_pos),
      .req_phi_pos      (req_phi_pos),
      .req_quality      (req_quality),
      .muon_eta_limit   (muon_eta_limit_ff),
      .muon_quality_min (muon_quality_min_ff),
      .eg_eta_limit     (eg_eta_limit_ff),
      .dr_squared_limit (dr_squared_limit_ff),
      .status           (status)
   );

   mtes_ctrl #(
      .MUON_STEPS (MUON_STEPS),
      .EG_STEPS   (EG_STEPS),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_opcode     (opcode),
      .req_bin_muon   (req_bin_muon),
      .req_bin_eg     (req_bin_eg),
      .threshold_step (threshold_step_ff),
      .rsp_busy       (rsp_valid_ff),
      .status         (status),
      .req_stall      (req_stall),
      .cmd            (cmd),
      .rd_result      (rd_result)
   );

   // Output register: a finished response waits here until it is taken.
   assign rsp_valid_in = rd_result.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_result.valid) begin
         rsp_bin_count_ff <= rd_result.count;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_count = rsp_bin_count_ff;

endmodule

// ----- src/mtes_checker.sv -----
// Port-level assertions for the threshold scanner and their binding to the top level.
`timescale 1ns / 1ps

module mtes_checker
   import mtes_pkg::*;
#(
   parameter int MUON_STEPS = 10
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_opcode,
   input logic [3:0]  req_bin_muon,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_bin_count
);

   logic read_accept;

   assign read_accept = req_valid && !req_stall && (req_opcode == OP_READ);

   // A held response keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bin_count))
      else $error("held response changed");

   // Every new response traces back to an accepted read request.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(read_accept, 2))
      else $error("response without a read request");

   // A read of a muon index outside the grid answers zero.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && ({2'b00, $past(req_bin_muon, 2)} >= 6'(MUON_STEPS))
      |-> rsp_bin_count == 32'd0)
      else $error("out-of-range bin read was not zero");

   // The memory read of a bin request blocks the next request.
   a_read_stall: assert property (@(posedge clock) disable iff (reset)
      read_accept |=> req_stall)
      else $error("request accepted during a bin read");

endmodule

bind muon_two_eg_threshold_scan mtes_checker #(
   .MUON_STEPS (MUON_STEPS)
) u_mtes_checker (.*);

// ----- verif/tb_muon_two_eg_threshold_scan.sv -----
// Self-checking testbench for the muon plus two e/gamma threshold-grid scanner.
`timescale 1ns / 1ps

module tb_muon_two_eg_threshold_scan;
   import mtes_pkg::*;

   localparam int MUON_STEPS  = 10;
   localparam int EG_STEPS    = 10;
   localparam int COUNT_BITS  = 32;
   localparam int PHI_STEPS   = 144;
   localparam int SETTLE      = 150;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [2:0] CSR_SPARE = 3'd7;

   // Mirrors the event selection and the grid counters, and keeps the bin
   // counts that read requests should return, oldest first.
   class threshold_grid_model;
      logic [6:0]         muon_eta_max;
      logic [3:0]         muon_qual_min;
      logic [6:0]         eg_eta_max;
      logic [15:0]        dr2_max;
      logic [7:0]         step;
      bit                 muon_seen;
      logic [8:0]         muon_et;
      int                 eg_count;
      logic [8:0]         eg_lead_et;
      logic signed [7:0]  eg_eta [2];
      logic [7:0]         eg_phi [2];
      logic [31:0]        counts [MUON_STEPS * EG_STEPS];
      logic [31:0]        expected_counts [$];
      int                 errors;
      int                 reads;
      int                 filled_events;

      function new();
         muon_eta_max  = MUON_ETA_LIMIT_RST;
         muon_qual_min = MUON_QUALITY_MIN_RST;
         eg_eta_max    = EG_ETA_LIMIT_RST;
         dr2_max       = DR_SQUARED_LIMIT_RST;
         step          = THRESHOLD_STEP_RST;
         foreach (counts[i]) counts[i] = '0;
         errors        = 0;
         reads         = 0;
         filled_events = 0;
         clear_event();
      endfunction

      function void clear_event();
         muon_seen  = 1'b0;
         muon_et    = '0;
         eg_count   = 0;
         eg_lead_et = '0;
         eg_eta[0]  = '0;
         eg_eta[1]  = '0;
         eg_phi[0]  = '0;
         eg_phi[1]  = '0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            CSR_MUON_ETA_LIMIT:   muon_eta_max  = data[6:0];
            CSR_MUON_QUALITY_MIN: muon_qual_min = data[3:0];
            CSR_EG_ETA_LIMIT:     eg_eta_max    = data[6:0];
            CSR_DR_SQUARED_LIMIT: dr2_max       = data;
            CSR_THRESHOLD_STEP:   step          = data[7:0];
            default: ;
         endcase
      endfunction

      function int abs_eta(logic signed [7:0] v);
         int x;
         x = int'(v);
         return (x < 0) ? -x : x;
      endfunction

      function void close_event();
         int     deta;
         int     dphi;
         longint dr2;
         if (eg_count == 2) begin
            deta = int'(eg_eta[0]) - int'(eg_eta[1]);
            dphi = (int'(eg_phi[0]) - int'(eg_phi[1])) % PHI_STEPS;
            if (dphi < 0) dphi += PHI_STEPS;
            if (dphi >= PHI_STEPS / 2) dphi -= PHI_STEPS;
            dr2 = longint'(deta * deta + dphi * dphi);
            if (dr2 <= dr2_max) begin
               filled_events++;
               for (int m = 0; m < MUON_STEPS; m++) begin
                  if (int'(muon_et) < m * int'(step)) continue;
                  for (int e = 0; e < EG_STEPS; e++) begin
                     if (int'(eg_lead_et) < e * int'(step)) continue;
                     if (counts[m * EG_STEPS + e] != '1)
                        counts[m * EG_STEPS + e]++;
                  end
               end
            end
         end
         clear_event();
      endfunction

      function void note_request(op_type op, logic [8:0] energy, logic signed [7:0] eta,
                                 logic [7:0] phi, logic [3:0] qual, logic [3:0] bm,
                                 logic [3:0] be);
         logic [31:0] want;
         case (op)
            OP_MUON: begin
               if (!muon_seen && abs_eta(eta) <= muon_eta_max && qual >= muon_qual_min) begin
                  muon_seen = 1'b1;
                  muon_et   = energy;
               end
            end
            OP_EG: begin
               if (eg_count < 2 && abs_eta(eta) <= eg_eta_max) begin
                  if (eg_count == 0) eg_lead_et = energy;
                  eg_eta[eg_count] = eta;
                  eg_phi[eg_count] = phi;
                  eg_count++;
               end
            end
            OP_END: close_event();
            default: begin
               if (bm < MUON_STEPS && be < EG_STEPS)
                  want = counts[bm * EG_STEPS + be];
               else
                  want = '0;
               expected_counts = {expected_counts, want};
            end
         endcase
      endfunction

      function void check_count(logic [31:0] actual);
         logic [31:0] want;
         if (expected_counts.size() == 0) begin
            $error("bin_count: no read pending, actual %0d", actual);
            errors++;
         end else begin
            want = expected_counts.pop_front();
            reads++;
            if (actual !== want) begin
               $error("bin_count mismatch: expected %0d, actual %0d", want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_counts.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [8:0]  req_energy = '0;
   logic [7:0]  req_eta_pos = '0;
   logic [7:0]  req_phi_pos = '0;
   logic [3:0]  req_quality = '0;
   logic [3:0]  req_bin_muon = '0;
   logic [3:0]  req_bin_eg = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_bin_count;

   threshold_grid_model sb;
   int          sent = 0;
   int          burst_left = 0;
   int          settings = 0;
   int          rsp_hold = 0;
   int          pattern_age = 0;
   logic [15:0] stall_pattern = '0;
   int          quiet_cycles = 0;

   muon_two_eg_threshold_scan #(
      .MUON_STEPS(MUON_STEPS),
      .EG_STEPS  (EG_STEPS),
      .COUNT_BITS(COUNT_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_energy   (req_energy),
      .req_eta_pos  (req_eta_pos),
      .req_phi_pos  (req_phi_pos),
      .req_quality  (req_quality),
      .req_bin_muon (req_bin_muon),
      .req_bin_eg   (req_bin_eg),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_bin_count(rsp_bin_count)
   );

   always #5 clock = ~clock;

   // Receiver: a long forced hold-off when asked, otherwise a rotating stall
   // pattern that is redrawn whenever its age counter runs out.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = 48;
            case ($urandom_range(0, 3))
               0: stall_pattern = '0;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'($urandom | $urandom);
               default: stall_pattern = 16'h8001;
            endcase
         end
         pattern_age--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         rsp_stall <= stall_pattern[0];
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_count(rsp_bin_count);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic put_reg(logic [2:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic write_regs(logic [6:0] mu_eta, logic [3:0] mu_qual, logic [6:0] eg_eta,
                             logic [15:0] dr2, logic [7:0] step);
      put_reg(CSR_MUON_ETA_LIMIT, {9'd0, mu_eta});
      put_reg(CSR_MUON_QUALITY_MIN, {12'd0, mu_qual});
      put_reg(CSR_EG_ETA_LIMIT, {9'd0, eg_eta});
      put_reg(CSR_DR_SQUARED_LIMIT, dr2);
      put_reg(CSR_THRESHOLD_STEP, {8'd0, step});
      @(negedge clock);
      csr_write <= 1'b0;
      settings++;
   endtask

   // One request; the sender may pause between bursts of random length.
   task automatic send(op_type op, logic [8:0] en, logic [7:0] eta, logic [7:0] phi,
                       logic [3:0] qual, logic [3:0] bm, logic [3:0] be);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_energy   <= en;
      req_eta_pos  <= eta;
      req_phi_pos  <= phi;
      req_quality  <= qual;
      req_bin_muon <= bm;
      req_bin_eg   <= be;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, en, eta, phi, qual, bm, be);
      sent++;
   endtask

   task automatic end_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [7:0] clip_eta(int v);
      if (v > 127) v = 127;
      if (v < -128) v = -128;
      return v[7:0];
   endfunction

   function automatic logic [7:0] eta_near(int lim, int spread);
      int r;
      if ($urandom_range(0, 7) == 0)
         r = int'($urandom_range(0, 255)) - 128;
      else
         r = int'($urandom_range(0, 2 * (lim + spread))) - lim - spread;
      return clip_eta(r);
   endfunction

   function automatic logic [8:0] pick_energy();
      logic [8:0] en;
      if ($urandom_range(0, 1) == 0)
         en = 9'($urandom_range(0, 40));
      else
         en = 9'($urandom_range(0, 511));
      return en;
   endfunction

   task automatic send_read();
      logic [3:0] bm;
      logic [3:0] be;
      bm = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, MUON_STEPS - 1));
      be = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, EG_STEPS - 1));
      send(OP_READ, 9'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), bm, be);
   endtask

   // A well-formed event: up to three muons and up to three e/gamma in random order, the
   // e/gamma clustered so that the pair often passes the distance cut.
   task automatic send_event();
      int n_mu;
      int n_eg;
      int base_eta;
      int base_phi;
      int p;
      int de;
      int dp;
      logic [7:0] eta;
      n_mu = $urandom_range(0, 3);
      n_eg = $urandom_range(0, 3);
      base_eta = int'($signed(eta_near(int'(sb.eg_eta_max), 2)));
      base_phi = $urandom_range(0, PHI_STEPS - 1);
      while (n_mu + n_eg > 0) begin
         if (n_eg == 0 || (n_mu > 0 && $urandom_range(0, 1) == 1)) begin
            send(OP_MUON, pick_energy(), eta_near(int'(sb.muon_eta_max), 3), 8'($urandom),
                 4'($urandom_range(0, 15)), 4'($urandom), 4'($urandom));
            n_mu--;
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               de = 0;
               dp = 0;
            end else begin
               de = int'($urandom_range(0, 8)) - 4;
               dp = int'($urandom_range(0, 12)) - 6;
            end
            if ($urandom_range(0, 3) == 0)
               eta = eta_near(int'(sb.eg_eta_max), 3);
            else
               eta = clip_eta(base_eta + de);
            p = (base_phi + dp + PHI_STEPS) % PHI_STEPS;
            if ($urandom_range(0, 5) == 0 && p < 256 - PHI_STEPS) p += PHI_STEPS;
            send(OP_EG, pick_energy(), eta, p[7:0], 4'($urandom), 4'($urandom),
                 4'($urandom));
            n_eg--;
         end
      end
      send(OP_END, 9'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), 4'($urandom),
           4'($urandom));
   endtask

   task automatic run_random(int n);
      int first;
      int r;
      first = sent;
      while (sent - first < n) begin
         r = $urandom_range(0, 99);
         if (r < 65)
            send_event();
         else if (r < 85)
            repeat ($urandom_range(1, 3)) send_read();
         else
            send(op_type'(2'($urandom_range(0, 3))), 9'($urandom), 8'($urandom),
                 8'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
      end
      end_phase();
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings.
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd0);
      send(OP_MUON, 9'd511, 8'h80, 8'd0, 4'd15, 4'd15, 4'd15);
      send(OP_MUON, 9'd300, 8'd23, 8'd10, 4'd11, 4'd0, 4'd0);
      send(OP_MUON, 9'd7, -8'sd23, 8'd20, 4'd12, 4'd0, 4'd0);
      send(OP_MUON, 9'd511, 8'd0, 8'd255, 4'd15, 4'd9, 4'd9);
      send(OP_EG, 9'd511, 8'd26, 8'd0, 4'd0, 4'd0, 4'd0);
      send(OP_EG, 9'd15, 8'd25, 8'd143, 4'd0, 4'd0, 4'd0);
      send(OP_EG, 9'd0, 8'd22, 8'd0, 4'd15, 4'd0, 4'd0);
      send(OP_EG, 9'd511, 8'd0, 8'd0, 4'd0, 4'd0, 4'd0);
      send(OP_END, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd0);
      send(OP_READ, 9'd511, 8'hFF, 8'hFF, 4'd15, 4'd3, 4'd7);
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd4, 4'd0);
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd9, 4'd9);
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd15, 4'd15);
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd10);
      // Phi beyond one turn: 200 folds onto 56, so the pair coincides.
      send(OP_EG, 9'd511, -8'sd25, 8'd200, 4'd0, 4'd0, 4'd0);
      send(OP_EG, 9'd100, -8'sd25, 8'd56, 4'd0, 4'd0, 4'd0);
      send(OP_END, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd0);
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd9);
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd1, 4'd0);
      send(OP_END, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd0);
      send(OP_EG, 9'd40, -8'sd5, 8'd255, 4'd0, 4'd0, 4'd0);
      send(OP_EG, 9'd40, 8'd20, 8'd72, 4'd0, 4'd0, 4'd0);
      send(OP_END, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd0);
      send(OP_READ, 9'd0, 8'd0, 8'd0, 4'd0, 4'd0, 4'd0);
      end_phase();

      // Widest acceptance, with a long receiver hold-off at the start.
      write_regs(7'd127, 4'd0, 7'd127, 16'hFFFF, 8'd1);
      put_reg(CSR_SPARE, 16'hFFFF);
      @(negedge clock);
      csr_write <= 1'b0;
      rsp_hold = HOLD_CYCLES;
      run_random(260);

      // Narrowest acceptance and the coarsest grid.
      write_regs(7'd0, 4'd15, 7'd0, 16'd0, 8'd255);
      run_random(200);

      // A zero step makes every threshold zero.
      write_regs(7'($urandom_range(10, 40)), 4'($urandom_range(4, 12)),
                 7'($urandom_range(10, 40)), 16'($urandom_range(50, 2000)), 8'd0);
      run_random(260);

      write_regs(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                 7'($urandom_range(0, 127)), 16'($urandom_range(0, 4000)),
                 8'($urandom_range(1, 60)));
      run_random(300);

      if (sb.pending() != 0) begin
         $error("bin_count: %0d reads never answered", sb.pending());
         sb.errors++;
      end
      $display("Covered %0d requests over %0d register settings plus the reset one;",
               sent, settings);
      $display("%0d bin reads compared, %0d events filled the grid.",
               sb.reads, sb.filled_events);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
